@@ design/tct_pkg.sv @@
// Shared types, constants and helpers for the temperature compensation tracker.
// Used by tct_front, tct_back and temperature_compensation_tracker; no dependencies.
package tct_pkg;

	// saturation limit of the consecutive failure count (1 to 3)
	localparam int MAX_FAILED_READS = 3;
	localparam int FAIL_W = $clog2(MAX_FAILED_READS + 1);

	// queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_AW = $clog2(Q_DEPTH);
	localparam int Q_CW = $clog2(Q_DEPTH + 1);

	localparam int ADC_W = 20;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_T1 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_T2 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_T3 = 2'd2;

	// command codes
	localparam logic CMD_READ_OK   = 1'b0;
	localparam logic CMD_READ_FAIL = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] raw_msb;
		logic [7:0] raw_lsb;
		logic [7:0] raw_xlsb;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic               temp_valid;
		logic [1:0]         fail_count;
		logic               status;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic             fail;
		logic [ADC_W-1:0] adc;
	} work_t;

	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
	} cal_t;

	// arithmetic right shift of a 32-bit two's complement word
	function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
		return $unsigned($signed(v) >>> n);
	endfunction

endpackage

@@ design/tct_front.sv @@
// Front end: takes input beats, assembles the raw sample and queues classified items.
// Depends on tct_pkg.
module tct_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  tct_pkg::in_item_t   sample,
	output logic                work_valid,
	input  logic                work_take,
	output tct_pkg::work_t      work
);

	tct_pkg::work_t             q_mem_q [tct_pkg::Q_DEPTH];
	logic [tct_pkg::Q_AW-1:0]   wr_ptr_q;
	logic [tct_pkg::Q_AW-1:0]   rd_ptr_q;
	logic [tct_pkg::Q_CW-1:0]   cnt_q;
	tct_pkg::work_t             classified;
	logic                       accept;

	function automatic logic [tct_pkg::Q_AW-1:0] ptr_inc(input logic [tct_pkg::Q_AW-1:0] p);
		if (p == tct_pkg::Q_AW'(tct_pkg::Q_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_comb begin
		classified.fail = (sample.cmd == tct_pkg::CMD_READ_FAIL);
		// drop the low nibble of the extra byte
		classified.adc  = {sample.raw_msb, sample.raw_lsb, sample.raw_xlsb[7:4]};
	end

	assign full       = (cnt_q == tct_pkg::Q_CW'(tct_pkg::Q_DEPTH));
	assign accept     = push && !full;
	assign work_valid = (cnt_q != '0);
	assign work       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem_q[wr_ptr_q] <= classified;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (work_take) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({accept, work_take})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		work_take |-> cnt_q != '0)
		else $error("front queue read while empty");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= tct_pkg::Q_CW'(tct_pkg::Q_DEPTH))
		else $error("front queue count out of range");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !work_take) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("front queue lost a beat");

endmodule

@@ design/tct_back.sv @@
// Back end: compensation sequencer on one shared 32x32 multiplier, tracker state
// and the result register. Depends on tct_pkg.
module tct_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                work_valid,
	output logic                work_take,
	input  tct_pkg::work_t      work,
	input  tct_pkg::cal_t       cal,
	output logic                empty,
	input  logic                pop,
	output tct_pkg::out_item_t  result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ   = 3'd1;
	localparam logic [2:0] ST_QUAD = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]                  state_q;
	logic [31:0]                 prod_q;
	logic [31:0]                 d2_q;
	logic [31:0]                 var1_q;
	logic [31:0]                 fine_q;
	logic [31:0]                 temp_q;
	logic                        valid_q;
	logic                        warn_q;
	logic [tct_pkg::FAIL_W-1:0]  fail_cnt_q;
	logic                        out_v_q;
	tct_pkg::out_item_t          out_q;

	logic [31:0] d1;
	logic [31:0] d2;
	logic [31:0] t2_ext;
	logic [31:0] t3_ext;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] mul_p;
	logic [31:0] fine5;
	logic [31:0] comp;
	logic        out_free;
	logic        fail_done;
	logic        ok_done;
	logic [tct_pkg::FAIL_W-1:0] fail_next;
	logic        at_limit;

	assign d1 = {15'b0, work.adc[19:3]} - {15'b0, cal.t1, 1'b0};
	assign d2 = {16'b0, work.adc[19:4]} - {16'b0, cal.t1};
	assign t2_ext = {{16{cal.t2[15]}}, cal.t2};
	assign t3_ext = {{16{cal.t3[15]}}, cal.t3};

	always_comb begin
		case (state_q)
			ST_SQ: begin
				mul_a = d2_q;
				mul_b = d2_q;
			end
			ST_QUAD: begin
				mul_a = tct_pkg::asr32(prod_q, 5'd12);
				mul_b = t3_ext;
			end
			default: begin
				mul_a = d1;
				mul_b = t2_ext;
			end
		endcase
	end

	// low word only: products wrap modulo 2^32
	assign mul_p = mul_a * mul_b;

	assign fine5 = {fine_q[29:0], 2'b00} + fine_q + 32'd128;
	assign comp  = tct_pkg::asr32(fine5, 5'd8);

	assign out_free  = !out_v_q || pop;
	assign fail_done = (state_q == ST_IDLE) && work_valid && work.fail && out_free;
	assign ok_done   = (state_q == ST_DONE) && out_free;
	assign work_take = (state_q == ST_IDLE) && work_valid && (!work.fail || out_free);

	always_comb begin
		if (fail_cnt_q < tct_pkg::FAIL_W'(tct_pkg::MAX_FAILED_READS)) begin
			fail_next = fail_cnt_q + 1'b1;
		end else begin
			fail_next = fail_cnt_q;
		end
		at_limit = (fail_next >= tct_pkg::FAIL_W'(tct_pkg::MAX_FAILED_READS));
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				prod_q <= mul_p;
				d2_q   <= d2;
			end
			ST_SQ: begin
				var1_q <= tct_pkg::asr32(prod_q, 5'd11);
				prod_q <= mul_p;
			end
			ST_QUAD: begin
				prod_q <= mul_p;
			end
			ST_SUM: begin
				fine_q <= var1_q + tct_pkg::asr32(prod_q, 5'd14);
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
		if (fail_done) begin
			out_q.temperature_centi <= temp_q;
			out_q.temp_valid        <= at_limit ? 1'b0 : valid_q;
			out_q.fail_count        <= 2'(fail_next);
			out_q.status            <= at_limit ? 1'b1 : warn_q;
		end else if (ok_done) begin
			out_q.temperature_centi <= comp;
			out_q.temp_valid        <= 1'b1;
			out_q.fail_count        <= 2'b00;
			out_q.status            <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			temp_q     <= '0;
			valid_q    <= 1'b0;
			warn_q     <= 1'b1;
			fail_cnt_q <= '0;
			out_v_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (work_take && !work.fail) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ:   state_q <= ST_QUAD;
				ST_QUAD: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_DONE;
				ST_DONE: begin
					// hold until the result register frees up
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (fail_done) begin
				fail_cnt_q <= fail_next;
				if (at_limit) begin
					valid_q <= 1'b0;
					warn_q  <= 1'b1;
				end
			end else if (ok_done) begin
				temp_q     <= comp;
				valid_q    <= 1'b1;
				warn_q     <= 1'b0;
				fail_cnt_q <= '0;
			end

			if (fail_done || ok_done) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign empty  = !out_v_q;
	assign result = out_q;

	a_valid_warn_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_q && warn_q))
		else $error("valid flag and warning both set");

	a_fail_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fail_cnt_q <= tct_pkg::FAIL_W'(tct_pkg::MAX_FAILED_READS))
		else $error("failure count above limit");

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		work_take |-> state_q == ST_IDLE)
		else $error("item taken while sequencer busy");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_free) |=> state_q == ST_DONE)
		else $error("result dropped while output register full");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !pop) |=> out_v_q && $stable(out_q))
		else $error("waiting result changed before pop");

endmodule

@@ design/temperature_compensation_tracker.sv @@
// Temperature compensation tracker: a read-failure item is registered into the result
// register as soon as the back end takes it; a successful read first goes through
// three passes through the single shared 32x32 multiplier, the sum and the final scale
// step, and the back end takes no new item until that read is through. A two-beat queue
// in front and a one-beat result register behind let input and output stall
// independently. Calibration writes are always ready and take effect at once; write them
// only while no item is in flight. Index three is ignored.
module temperature_compensation_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  tct_pkg::in_item_t                   sample,
	output logic                                empty,
	input  logic                                pop,
	output tct_pkg::out_item_t                  result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tct_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [15:0]                         cfg_data
);

	tct_pkg::cal_t   cal_q;
	tct_pkg::work_t  work;
	logic            work_valid;
	logic            work_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tct_pkg::REG_CAL_T1: cal_q.t1 <= cfg_data;
				tct_pkg::REG_CAL_T2: cal_q.t2 <= cfg_data;
				tct_pkg::REG_CAL_T3: cal_q.t3 <= cfg_data;
				default:             cal_q    <= cal_q;
			endcase
		end
	end

	tct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample     (sample),
		.work_valid (work_valid),
		.work_take  (work_take),
		.work       (work)
	);

	tct_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_valid (work_valid),
		.work_take  (work_take),
		.work       (work),
		.cal        (cal_q),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

@@ verif/tb.sv @@
// Testbench for temperature_compensation_tracker: directed and random sensor reads and
// read failures under several calibration settings, checked beat by beat against an
// in-bench prediction of the compensation and failure tracking. Depends on tct_pkg.
module tb;

	localparam logic [tct_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int RANDOM_PER_PHASE = 150;
	localparam int RANDOM_PHASES = 9;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES = 160;
	localparam int HOLD_SPACING = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	tct_pkg::in_item_t sample = '0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic [tct_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic full;
	logic empty;
	logic cfg_ready;
	tct_pkg::out_item_t result;

	temperature_compensation_tracker dut (.*);

	always #2 clk = ~clk;

	// tracker state as the testbench sees it
	tct_pkg::cal_t cal_shadow = '0;
	logic signed [31:0] stored_centi = '0;
	logic valid_now = 1'b0;
	int fails_now = 0;
	logic warn_now = 1'b1;

	tct_pkg::in_item_t sensor_reads[$];
	tct_pkg::out_item_t expected_readings[$];

	int n_accepted = 0;
	int n_checked = 0;
	int n_mismatch = 0;
	int n_ok_reads = 0;
	int n_failed_reads = 0;
	int n_cal_settings = 0;
	int hold_cnt = 0;
	int hold_next = 400;

	function automatic logic signed [31:0] compensate_centi(input logic [19:0] adc);
		logic signed [31:0] adc_w, t1_w, t2_w, t3_w, d1, d2, var1, var2, sq, fine, scaled;
		adc_w = {12'd0, adc};
		t1_w = {16'd0, cal_shadow.t1};
		t2_w = {{16{cal_shadow.t2[15]}}, cal_shadow.t2};
		t3_w = {{16{cal_shadow.t3[15]}}, cal_shadow.t3};
		// every step wraps at 32 bits, shifts are arithmetic
		d1 = (adc_w >>> 3) - (t1_w <<< 1);
		var1 = (d1 * t2_w) >>> 11;
		d2 = (adc_w >>> 4) - t1_w;
		sq = (d2 * d2) >>> 12;
		var2 = (sq * t3_w) >>> 14;
		fine = var1 + var2;
		scaled = fine * 5 + 128;
		return scaled >>> 8;
	endfunction

	function automatic tct_pkg::out_item_t advance_tracker(input tct_pkg::in_item_t s);
		tct_pkg::out_item_t r;
		if (s.cmd == tct_pkg::CMD_READ_OK) begin
			stored_centi = compensate_centi({s.raw_msb, s.raw_lsb, s.raw_xlsb[7:4]});
			valid_now = 1'b1;
			fails_now = 0;
			warn_now = 1'b0;
			n_ok_reads++;
		end else begin
			if (fails_now < tct_pkg::MAX_FAILED_READS)
				fails_now++;
			if (fails_now >= tct_pkg::MAX_FAILED_READS) begin
				valid_now = 1'b0;
				warn_now = 1'b1;
			end
			n_failed_reads++;
		end
		r.temperature_centi = stored_centi;
		r.temp_valid = valid_now;
		r.fail_count = fails_now[1:0];
		r.status = warn_now;
		return r;
	endfunction

	function automatic tct_pkg::in_item_t make_read(input logic [7:0] m,
			input logic [7:0] l, input logic [7:0] x);
		tct_pkg::in_item_t it;
		it.cmd = tct_pkg::CMD_READ_OK;
		it.raw_msb = m;
		it.raw_lsb = l;
		it.raw_xlsb = x;
		return it;
	endfunction

	function automatic tct_pkg::in_item_t make_fail();
		tct_pkg::in_item_t it;
		it.cmd = tct_pkg::CMD_READ_FAIL;
		it.raw_msb = 8'($urandom);
		it.raw_lsb = 8'($urandom);
		it.raw_xlsb = 8'($urandom);
		return it;
	endfunction

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom);
	endfunction

	task automatic write_cal(input logic [tct_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tct_pkg::REG_CAL_T1: cal_shadow.t1 = data;
			tct_pkg::REG_CAL_T2: cal_shadow.t2 = data;
			tct_pkg::REG_CAL_T3: cal_shadow.t3 = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic program_cal(input logic [15:0] t1, input logic [15:0] t2,
			input logic [15:0] t3);
		write_cal(tct_pkg::REG_CAL_T1, t1);
		write_cal(REG_UNUSED, 16'($urandom));
		write_cal(tct_pkg::REG_CAL_T2, t2);
		write_cal(tct_pkg::REG_CAL_T3, t3);
		n_cal_settings++;
	endtask

	// hold until every queued read is through and every reading is back
	task automatic settle();
		while (sensor_reads.size() != 0 || expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_random_reads(input int n);
		int left;
		int run;
		logic fail_run;
		left = n;
		while (left > 0) begin
			fail_run = ($urandom_range(0, 3) == 0);
			run = fail_run ? $urandom_range(1, 5) : $urandom_range(1, 6);
			if (run > left)
				run = left;
			repeat (run)
				sensor_reads.push_back(fail_run ? make_fail()
					: make_read(pick_byte(), pick_byte(), pick_byte()));
			left -= run;
		end
	endtask

	// sender: bursts of offered beats with random gaps, no gaps during a receiver hold-off
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (push && !full) begin
			expected_readings.push_back(advance_tracker(sample));
			void'(sensor_reads.pop_front());
			n_accepted++;
		end
		if (hold_cnt == 0 && gap_left > 0) begin
			gap_left--;
			push <= 1'b0;
		end else if (sensor_reads.size() > 0) begin
			push <= 1'b1;
			sample <= sensor_reads[0];
			if (burst_left > 0)
				burst_left--;
			else begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			end
		end else begin
			push <= 1'b0;
		end
	end

	// long receiver hold-offs so the block backs up into its input
	always @(posedge clk) begin
		if (hold_cnt > 0)
			hold_cnt <= hold_cnt - 1;
		else if (n_accepted >= hold_next) begin
			hold_cnt <= HOLD_CYCLES;
			hold_next <= hold_next + HOLD_SPACING;
		end
	end

	// receiver: checks each accepted beat, pops on a pattern that changes every so often
	int rx_mode = 0;
	int rx_span = 0;
	always @(posedge clk) begin : rx
		tct_pkg::out_item_t want;
		if (arst_n && pop && !empty) begin
			if (expected_readings.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected result beat: temp %0d valid %0b fails %0d status %0b",
						$signed(result.temperature_centi), result.temp_valid,
						result.fail_count, result.status);
			end else begin
				want = expected_readings.pop_front();
				n_checked++;
				if (result.temperature_centi !== want.temperature_centi
						|| result.temp_valid !== want.temp_valid
						|| result.fail_count !== want.fail_count
						|| result.status !== want.status) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch on beat %0d: expected temp %0d valid %0b",
							n_checked, $signed(want.temperature_centi), want.temp_valid,
							" fails %0d status %0b,", want.fail_count, want.status,
							" got temp %0d valid %0b",
							$signed(result.temperature_centi), result.temp_valid,
							" fails %0d status %0b", result.fail_count, result.status);
				end
			end
		end
		if (rx_span == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_span = $urandom_range(20, 120);
		end else
			rx_span--;
		if (hold_cnt != 0)
			pop <= 1'b0;
		else case (rx_mode)
			0: pop <= 1'b1;
			1: pop <= 1'($urandom_range(0, 1));
			default: pop <= ($urandom_range(0, 3) == 0);
		endcase
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset calibration, starting from the not-started warning
		sensor_reads.push_back(make_fail());
		sensor_reads.push_back(make_read(8'h80, 8'h00, 8'h00));
		sensor_reads.push_back(make_fail());
		settle();

		program_cal(16'd27504, 16'd26435, -16'sd1000);
		sensor_reads.push_back(make_read(8'h7E, 8'hED, 8'h00));
		sensor_reads.push_back(make_read(8'h00, 8'h00, 8'h00));
		sensor_reads.push_back(make_read(8'hFF, 8'hFF, 8'hFF));
		sensor_reads.push_back(make_read(8'hFF, 8'hFF, 8'hF0));
		// low nibble of the extra byte must not matter
		sensor_reads.push_back(make_read(8'h80, 8'h00, 8'h0F));
		sensor_reads.push_back(make_read(8'h80, 8'h00, 8'h00));
		// climb to the failure limit and stay there
		repeat (4) sensor_reads.push_back(make_fail());
		// raw value equal to the first calibration word
		sensor_reads.push_back(make_read(8'h6B, 8'h70, 8'h00));
		repeat (2) sensor_reads.push_back(make_fail());
		sensor_reads.push_back(make_read(8'h55, 8'hAA, 8'h5A));
		repeat (3) sensor_reads.push_back(make_fail());
		sensor_reads.push_back(make_read(8'hAA, 8'h55, 8'hA5));
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: program_cal(16'd27504, 16'd26435, -16'sd1000);
				1: begin
					program_cal(16'h0000, 16'h8000, 16'h8000);
					// products wrap here
					sensor_reads.push_back(make_read(8'hFF, 8'hFF, 8'hF0));
					sensor_reads.push_back(make_read(8'h00, 8'h00, 8'h00));
				end
				2: program_cal(16'hFFFF, 16'h7FFF, 16'h7FFF);
				3: program_cal(16'hFFFF, 16'h8000, 16'h7FFF);
				4: program_cal(16'h0000, 16'h7FFF, 16'h8000);
				default: program_cal(16'($urandom), 16'($urandom), 16'($urandom));
			endcase
			add_random_reads(RANDOM_PER_PHASE);
			settle();
		end

		$display("covered %0d good reads and %0d read failures over %0d calibration settings",
			n_ok_reads, n_failed_reads, n_cal_settings);
		$display("%0d result beats checked, %0d mismatches", n_checked, n_mismatch);
		if (n_mismatch == 0 && expected_readings.size() == 0)
			$display("[temperature_compensation_tracker] OK");
		else
			$display("[temperature_compensation_tracker] ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d readings outstanding", expected_readings.size());
		$display("[temperature_compensation_tracker] ERROR");
		$finish;
	end

endmodule
